>>> sv/mwsl_pkg.sv
// mwsl_pkg: shared widths, register indexes, constants and types for the
// mecanum wheel speed limiter. No dependencies.
package mwsl_pkg;

    // field widths
    localparam int HB_W  = 12;
    localparam int RAD_W = 10;
    localparam int MAX_W = 16;
    localparam int IN_W  = 16;
    localparam int SPD_W = 17;

    // configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_ADDR_W-1:0] REG_HALF_BASE    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_WHEEL_RADIUS = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_SPEED    = 2'd2;
    localparam logic [HB_W-1:0]  RST_HALF_BASE    = 12'd200;
    localparam logic [RAD_W-1:0] RST_WHEEL_RADIUS = 10'd40;
    localparam logic [MAX_W-1:0] RST_MAX_SPEED    = 16'd10000;

    // internal widths
    localparam int FRAC_W = 16;              // fraction bits of the velocity vector
    localparam int KW_W   = 29;              // yaw rate times half base sum
    localparam int CF_W   = 32;              // forward / lateral component
    localparam int CT_W   = 44;              // rotation component
    localparam int SUM_W  = 33;
    localparam int P_W    = 49;              // 60000 * (cf +/- cl)
    localparam int T_W    = 50;              // 60 * ct
    localparam int NUM_W  = 51;              // wheel numerator
    localparam int DIVS_W = 20;              // 1000 * radius
    localparam int LIM_W  = 36;              // max speed * 1000 * radius
    localparam int SCL_W  = 17;
    localparam int MOP_W  = 32;
    localparam int MSC_W  = 16;
    localparam int PROD_W = MOP_W + MSC_W;
    localparam int CT_LO_W = 22;
    localparam int CT_HI_W = 21;
    localparam int ACC_W  = CT_LO_W + MSC_W;
    localparam int Q_W    = 16;
    localparam int REM_W  = NUM_W - FRAC_W;
    localparam int BIT_W  = 4;
    localparam int WHL_W  = 2;
    localparam int CNT_W  = 3;

    localparam logic [RAD_W-1:0]  RAD_MIN    = 10'd1;
    localparam logic [DIVS_W-1:0] MM_PER_M   = 20'd1000;
    localparam logic signed [16:0] SUM_GAIN  = 17'sd60000;
    localparam logic signed [7:0]  ROT_GAIN  = 8'sd60;
    localparam logic [SCL_W-1:0]  SCALE_ONE  = 17'h10000;
    localparam logic [SCL_W-1:0]  SCALE_STEP = 17'd2185;

    // multiplier operand select during a scaling pass
    localparam logic [WHL_W-1:0] MSEL_CF    = 2'd0;
    localparam logic [WHL_W-1:0] MSEL_CL    = 2'd1;
    localparam logic [WHL_W-1:0] MSEL_CT_LO = 2'd2;
    localparam logic [WHL_W-1:0] MSEL_CT_HI = 2'd3;

    typedef struct packed {
        logic [HB_W-1:0]  half_base;
        logic [RAD_W-1:0] radius;
        logic [MAX_W-1:0] max_speed;
    } t_cfg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LIM,
        S_SUMS,
        S_S60,
        S_CHECK,
        S_DECIDE,
        S_MUL,
        S_DLOAD,
        S_DINIT,
        S_DSTEP,
        S_DSTORE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic             ld_in;
        logic             lim_ld;
        logic             sums_ld;
        logic             s60_ld;
        logic             num_ld;
        logic [WHL_W-1:0] num_sel;
        logic             chk_clr;
        logic             chk_acc;
        logic             scale_dec;
        logic             zero_res;
        logic             mul_ld;
        logic [WHL_W-1:0] mul_sel;
        logic             wb;
        logic [WHL_W-1:0] wb_sel;
        logic             div_init;
        logic             div_step;
        logic             res_st;
        logic [WHL_W-1:0] res_sel;
        logic             out_ld;
    } t_cmd;

    typedef struct packed {
        logic over;
        logic exhaust;
    } t_sts;

endpackage

>>> sv/mwsl_regs.sv
// mwsl_regs: configuration registers of the wheel speed limiter.
// Depends on mwsl_pkg.
module mwsl_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mwsl_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [mwsl_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    output mwsl_pkg::t_cfg                      o_cfg
);

    mwsl_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_base <= mwsl_pkg::RST_HALF_BASE;
            r_cfg.radius    <= mwsl_pkg::RST_WHEEL_RADIUS;
            r_cfg.max_speed <= mwsl_pkg::RST_MAX_SPEED;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                mwsl_pkg::REG_HALF_BASE: begin
                    r_cfg.half_base <= i_cfg_wdata[mwsl_pkg::HB_W-1:0];
                end
                mwsl_pkg::REG_WHEEL_RADIUS: begin
                    r_cfg.radius <= i_cfg_wdata[mwsl_pkg::RAD_W-1:0];
                end
                mwsl_pkg::REG_MAX_SPEED: begin
                    r_cfg.max_speed <= i_cfg_wdata[mwsl_pkg::MAX_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> sv/mwsl_dp.sv
// mwsl_dp: datapath of the wheel speed limiter: velocity vector, limit check,
// shared scaling multiplier, restoring divider and result registers.
// Depends on mwsl_pkg; driven by mwsl_ctrl commands.
module mwsl_dp #(
    parameter logic [mwsl_pkg::SCL_W-1:0] SCALE_STEP = mwsl_pkg::SCALE_STEP
) (
    input  logic                                 i_clk,
    input  mwsl_pkg::t_cmd                       i_cmd,
    output mwsl_pkg::t_sts                       o_sts,
    input  mwsl_pkg::t_cfg                       i_cfg,
    input  logic signed [mwsl_pkg::IN_W-1:0]     i_vel_forward,
    input  logic signed [mwsl_pkg::IN_W-1:0]     i_vel_lateral,
    input  logic signed [mwsl_pkg::IN_W-1:0]     i_yaw_rate,
    output logic signed [mwsl_pkg::SPD_W-1:0]    o_speed_front_right,
    output logic signed [mwsl_pkg::SPD_W-1:0]    o_speed_front_left,
    output logic signed [mwsl_pkg::SPD_W-1:0]    o_speed_back_left,
    output logic signed [mwsl_pkg::SPD_W-1:0]    o_speed_back_right,
    output logic                                 o_was_scaled
);

    localparam int NUM_W = mwsl_pkg::NUM_W;

    logic signed [mwsl_pkg::CF_W-1:0]  r_cf, r_cl;
    logic signed [mwsl_pkg::CT_W-1:0]  r_ct;
    logic [mwsl_pkg::DIVS_W-1:0]       r_div;
    logic [mwsl_pkg::LIM_W-1:0]        r_lim;
    logic [mwsl_pkg::SCL_W-1:0]        r_scale;
    logic                              r_scaled;
    logic signed [mwsl_pkg::SUM_W-1:0] r_sp, r_sm;
    logic signed [mwsl_pkg::P_W-1:0]   r_p, r_m;
    logic signed [mwsl_pkg::T_W-1:0]   r_t;
    logic signed [NUM_W-1:0]           r_num;
    logic                              r_over;
    logic [mwsl_pkg::PROD_W-1:0]       r_prod;
    logic [mwsl_pkg::ACC_W-1:0]        r_acc;
    logic [mwsl_pkg::REM_W-1:0]        r_rem, r_dsh;
    logic [mwsl_pkg::Q_W-1:0]          r_q;
    logic                              r_neg;
    logic signed [mwsl_pkg::SPD_W-1:0] r_res [4];
    logic signed [mwsl_pkg::SPD_W-1:0] r_o_fr, r_o_fl, r_o_bl, r_o_br;
    logic                              r_o_scaled;

    logic [mwsl_pkg::RAD_W-1:0]        w_rad;
    logic [mwsl_pkg::DIVS_W-1:0]       w_div;
    logic signed [mwsl_pkg::KW_W-1:0]  w_kw;
    logic signed [mwsl_pkg::P_W:0]     w_p_full, w_m_full;
    logic signed [mwsl_pkg::T_W+1:0]   w_t_full;
    logic signed [NUM_W-1:0]           w_a, w_tx, w_num;
    logic [NUM_W-1:0]                  w_mag;
    logic                              w_over;
    logic [mwsl_pkg::CF_W-1:0]         w_cf_mag, w_cl_mag;
    logic [mwsl_pkg::CT_W-1:0]         w_ct_mag;
    logic [mwsl_pkg::MOP_W-1:0]        w_mop;
    logic [mwsl_pkg::PROD_W-1:0]       w_prod;
    logic [mwsl_pkg::CF_W-1:0]         w_fmag;
    logic [mwsl_pkg::ACC_W+mwsl_pkg::CT_LO_W-1:0] w_ct_sum;
    logic [mwsl_pkg::CT_W-1:0]         w_ctn_mag;
    logic                              w_ge;
    logic [mwsl_pkg::REM_W-1:0]        w_rem_sub;
    logic [mwsl_pkg::SPD_W-1:0]        w_q_ext;

    function automatic logic signed [mwsl_pkg::T_W+1:0] mul_rot_gain(
        input logic signed [mwsl_pkg::CT_W-1:0] ct
    );
        logic signed [mwsl_pkg::T_W+1:0] ext;
        ext = {{(mwsl_pkg::T_W+2-mwsl_pkg::CT_W){ct[mwsl_pkg::CT_W-1]}}, ct};
        return ext * mwsl_pkg::ROT_GAIN;
    endfunction

    // divisor and rotation term
    assign w_rad = (i_cfg.radius == '0) ? mwsl_pkg::RAD_MIN : i_cfg.radius;
    assign w_div = mwsl_pkg::DIVS_W'(w_rad) * mwsl_pkg::MM_PER_M;
    assign w_kw  = i_yaw_rate * $signed({1'b0, i_cfg.half_base});

    assign w_p_full = r_sp * mwsl_pkg::SUM_GAIN;
    assign w_m_full = r_sm * mwsl_pkg::SUM_GAIN;
    assign w_t_full = mul_rot_gain(r_ct);

    // wheel numerator: front right P+T, front left M-T, back left P-T, back right M+T
    always_comb begin
        if (i_cmd.num_sel[0]) begin
            w_a = {{(NUM_W-mwsl_pkg::P_W){r_m[mwsl_pkg::P_W-1]}}, r_m};
        end else begin
            w_a = {{(NUM_W-mwsl_pkg::P_W){r_p[mwsl_pkg::P_W-1]}}, r_p};
        end
        w_tx = {{(NUM_W-mwsl_pkg::T_W){r_t[mwsl_pkg::T_W-1]}}, r_t};
        if (i_cmd.num_sel[1] == i_cmd.num_sel[0]) begin
            w_num = w_a + w_tx;
        end else begin
            w_num = w_a - w_tx;
        end
    end

    assign w_mag  = r_num[NUM_W-1] ? (~r_num + 1'b1) : r_num;
    assign w_over = {1'b0, w_mag} > {r_lim, {mwsl_pkg::FRAC_W{1'b0}}};

    // magnitudes for the scaling multiplier
    assign w_cf_mag = r_cf[mwsl_pkg::CF_W-1] ? (~r_cf + 1'b1) : r_cf;
    assign w_cl_mag = r_cl[mwsl_pkg::CF_W-1] ? (~r_cl + 1'b1) : r_cl;
    assign w_ct_mag = r_ct[mwsl_pkg::CT_W-1] ? (~r_ct + 1'b1) : r_ct;

    always_comb begin
        case (i_cmd.mul_sel)
            mwsl_pkg::MSEL_CF: w_mop = w_cf_mag;
            mwsl_pkg::MSEL_CL: w_mop = w_cl_mag;
            mwsl_pkg::MSEL_CT_LO: begin
                w_mop = mwsl_pkg::MOP_W'(w_ct_mag[mwsl_pkg::CT_LO_W-1:0]);
            end
            mwsl_pkg::MSEL_CT_HI: begin
                w_mop = mwsl_pkg::MOP_W'(
                    w_ct_mag[mwsl_pkg::CT_LO_W+mwsl_pkg::CT_HI_W-1:mwsl_pkg::CT_LO_W]);
            end
            default: w_mop = '0;
        endcase
    end

    assign w_prod = w_mop * r_scale[mwsl_pkg::MSC_W-1:0];
    assign w_fmag = r_prod[mwsl_pkg::PROD_W-1:mwsl_pkg::FRAC_W];

    // rotation component: high partial product shifted past the low one
    assign w_ct_sum = {1'b0, r_prod[mwsl_pkg::CT_HI_W+mwsl_pkg::MSC_W-1:0],
                       {mwsl_pkg::CT_LO_W{1'b0}}}
                    + {{(mwsl_pkg::CT_LO_W){1'b0}}, r_acc};
    assign w_ctn_mag = w_ct_sum[mwsl_pkg::CT_W+mwsl_pkg::FRAC_W-1:mwsl_pkg::FRAC_W];

    // one quotient bit per step
    assign w_ge      = r_rem >= r_dsh;
    assign w_rem_sub = r_rem - r_dsh;
    assign w_q_ext   = {1'b0, r_q};

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_in) begin
            r_cf     <= {i_vel_forward, {mwsl_pkg::FRAC_W{1'b0}}};
            r_cl     <= {i_vel_lateral, {mwsl_pkg::FRAC_W{1'b0}}};
            r_ct     <= {w_kw[mwsl_pkg::CT_W-mwsl_pkg::FRAC_W-1:0],
                         {mwsl_pkg::FRAC_W{1'b0}}};
            r_div    <= w_div;
            r_scale  <= mwsl_pkg::SCALE_ONE;
            r_scaled <= 1'b0;
        end
        if (i_cmd.lim_ld) begin
            r_lim <= mwsl_pkg::LIM_W'(i_cfg.max_speed) * mwsl_pkg::LIM_W'(r_div);
        end
        if (i_cmd.sums_ld) begin
            r_sp <= {r_cf[mwsl_pkg::CF_W-1], r_cf} + {r_cl[mwsl_pkg::CF_W-1], r_cl};
            r_sm <= {r_cf[mwsl_pkg::CF_W-1], r_cf} - {r_cl[mwsl_pkg::CF_W-1], r_cl};
        end
        if (i_cmd.s60_ld) begin
            r_p <= w_p_full[mwsl_pkg::P_W-1:0];
            r_m <= w_m_full[mwsl_pkg::P_W-1:0];
            r_t <= w_t_full[mwsl_pkg::T_W-1:0];
        end
        if (i_cmd.num_ld) begin
            r_num <= w_num;
        end
        if (i_cmd.chk_clr) begin
            r_over <= 1'b0;
        end else if (i_cmd.chk_acc) begin
            r_over <= r_over | w_over;
        end
        if (i_cmd.scale_dec) begin
            r_scale  <= r_scale - SCALE_STEP;
            r_scaled <= 1'b1;
        end
        if (i_cmd.mul_ld) begin
            r_prod <= w_prod;
        end
        if (i_cmd.wb) begin
            case (i_cmd.wb_sel)
                mwsl_pkg::MSEL_CF: begin
                    r_cf <= r_cf[mwsl_pkg::CF_W-1] ? (~w_fmag + 1'b1) : w_fmag;
                end
                mwsl_pkg::MSEL_CL: begin
                    r_cl <= r_cl[mwsl_pkg::CF_W-1] ? (~w_fmag + 1'b1) : w_fmag;
                end
                mwsl_pkg::MSEL_CT_LO: begin
                    r_acc <= r_prod[mwsl_pkg::ACC_W-1:0];
                end
                mwsl_pkg::MSEL_CT_HI: begin
                    r_ct <= r_ct[mwsl_pkg::CT_W-1] ? (~w_ctn_mag + 1'b1) : w_ctn_mag;
                end
                default: begin
                end
            endcase
        end
        if (i_cmd.div_init) begin
            r_rem <= w_mag[NUM_W-1:mwsl_pkg::FRAC_W];
            r_dsh <= {r_div, {(mwsl_pkg::Q_W-1){1'b0}}};
            r_q   <= '0;
            r_neg <= r_num[NUM_W-1];
        end
        if (i_cmd.div_step) begin
            if (w_ge) begin
                r_rem <= w_rem_sub;
            end
            r_q   <= {r_q[mwsl_pkg::Q_W-2:0], w_ge};
            r_dsh <= r_dsh >> 1;
        end
        if (i_cmd.zero_res) begin
            for (int i = 0; i < 4; i++) begin
                r_res[i] <= '0;
            end
        end else if (i_cmd.res_st) begin
            r_res[i_cmd.res_sel] <= r_neg ? (~w_q_ext + 1'b1) : w_q_ext;
        end
        if (i_cmd.out_ld) begin
            r_o_fr     <= r_res[0];
            r_o_fl     <= r_res[1];
            r_o_bl     <= r_res[2];
            r_o_br     <= r_res[3];
            r_o_scaled <= r_scaled;
        end
    end

    assign o_sts.over    = r_over;
    assign o_sts.exhaust = r_scale <= SCALE_STEP;

    assign o_speed_front_right = r_o_fr;
    assign o_speed_front_left  = r_o_fl;
    assign o_speed_back_left   = r_o_bl;
    assign o_speed_back_right  = r_o_br;
    assign o_was_scaled        = r_o_scaled;

endmodule

>>> sv/mwsl_ctrl.sv
// mwsl_ctrl: sequencer for the wheel speed limiter: limit passes, scaling
// multiplies, per-wheel division and output handoff. Depends on mwsl_pkg.
module mwsl_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  mwsl_pkg::t_sts i_sts,
    output mwsl_pkg::t_cmd o_cmd
);

    localparam logic [mwsl_pkg::CNT_W-1:0] CNT_LAST   = 3'd4;
    localparam logic [mwsl_pkg::BIT_W-1:0] BIT_LAST   = 4'd15;
    localparam logic [mwsl_pkg::WHL_W-1:0] WHEEL_LAST = 2'd3;

    mwsl_pkg::t_state               r_state, n_state;
    logic [mwsl_pkg::CNT_W-1:0]     r_cnt, n_cnt;
    logic [mwsl_pkg::WHL_W-1:0]     r_wheel, n_wheel;
    logic [mwsl_pkg::BIT_W-1:0]     r_bit, n_bit;
    logic                           r_out_valid, n_out_valid;
    logic                           w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mwsl_pkg::S_IDLE:   if (i_in_valid) n_state = mwsl_pkg::S_LIM;
            mwsl_pkg::S_LIM:    n_state = mwsl_pkg::S_SUMS;
            mwsl_pkg::S_SUMS:   n_state = mwsl_pkg::S_S60;
            mwsl_pkg::S_S60:    n_state = mwsl_pkg::S_CHECK;
            mwsl_pkg::S_CHECK:  if (r_cnt == CNT_LAST) n_state = mwsl_pkg::S_DECIDE;
            mwsl_pkg::S_DECIDE: begin
                if (!i_sts.over) begin
                    n_state = mwsl_pkg::S_DLOAD;
                end else if (i_sts.exhaust) begin
                    n_state = mwsl_pkg::S_DONE;
                end else begin
                    n_state = mwsl_pkg::S_MUL;
                end
            end
            mwsl_pkg::S_MUL:    if (r_cnt == CNT_LAST) n_state = mwsl_pkg::S_SUMS;
            mwsl_pkg::S_DLOAD:  n_state = mwsl_pkg::S_DINIT;
            mwsl_pkg::S_DINIT:  n_state = mwsl_pkg::S_DSTEP;
            mwsl_pkg::S_DSTEP:  if (r_bit == BIT_LAST) n_state = mwsl_pkg::S_DSTORE;
            mwsl_pkg::S_DSTORE: begin
                n_state = (r_wheel == WHEEL_LAST) ? mwsl_pkg::S_DONE : mwsl_pkg::S_DLOAD;
            end
            mwsl_pkg::S_DONE:   if (w_out_free) n_state = mwsl_pkg::S_IDLE;
            default:            n_state = mwsl_pkg::S_IDLE;
        endcase
    end

    // counters
    always_comb begin
        n_cnt   = r_cnt;
        n_wheel = r_wheel;
        n_bit   = r_bit;
        case (r_state)
            mwsl_pkg::S_S60:    n_cnt = '0;
            mwsl_pkg::S_CHECK:  n_cnt = r_cnt + 1'b1;
            mwsl_pkg::S_DECIDE: begin
                n_cnt   = '0;
                n_wheel = '0;
            end
            mwsl_pkg::S_MUL:    n_cnt = r_cnt + 1'b1;
            mwsl_pkg::S_DINIT:  n_bit = '0;
            mwsl_pkg::S_DSTEP:  n_bit = r_bit + 1'b1;
            mwsl_pkg::S_DSTORE: n_wheel = r_wheel + 1'b1;
            default: begin
            end
        endcase
    end

    // commands
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            mwsl_pkg::S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.ld_in  = i_in_valid;
            end
            mwsl_pkg::S_LIM:  o_cmd.lim_ld  = 1'b1;
            mwsl_pkg::S_SUMS: o_cmd.sums_ld = 1'b1;
            mwsl_pkg::S_S60:  o_cmd.s60_ld  = 1'b1;
            mwsl_pkg::S_CHECK: begin
                // numerator of wheel n is loaded, checked when the count reaches n+1
                o_cmd.num_ld  = (r_cnt != CNT_LAST);
                o_cmd.num_sel = r_cnt[mwsl_pkg::WHL_W-1:0];
                o_cmd.chk_clr = (r_cnt == '0);
                o_cmd.chk_acc = (r_cnt != '0);
            end
            mwsl_pkg::S_DECIDE: begin
                o_cmd.scale_dec = i_sts.over;
                o_cmd.zero_res  = i_sts.over && i_sts.exhaust;
            end
            mwsl_pkg::S_MUL: begin
                o_cmd.mul_ld  = (r_cnt != CNT_LAST);
                o_cmd.mul_sel = r_cnt[mwsl_pkg::WHL_W-1:0];
                o_cmd.wb      = (r_cnt != '0);
                o_cmd.wb_sel  = mwsl_pkg::WHL_W'(r_cnt - 1'b1);
            end
            mwsl_pkg::S_DLOAD: begin
                o_cmd.num_ld  = 1'b1;
                o_cmd.num_sel = r_wheel;
            end
            mwsl_pkg::S_DINIT: o_cmd.div_init = 1'b1;
            mwsl_pkg::S_DSTEP: o_cmd.div_step = 1'b1;
            mwsl_pkg::S_DSTORE: begin
                o_cmd.res_st  = 1'b1;
                o_cmd.res_sel = r_wheel;
            end
            mwsl_pkg::S_DONE: o_cmd.out_ld = w_out_free;
            default: begin
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_ld) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mwsl_pkg::S_IDLE;
            r_cnt       <= '0;
            r_wheel     <= '0;
            r_bit       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_wheel     <= n_wheel;
            r_bit       <= n_bit;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> sv/mecanum_wheel_speed_limiter.sv
// channel  dir  handshake                 payload
// in       in   i_in_valid / o_in_ready   i_vel_forward, i_vel_lateral, i_yaw_rate
// out      out  o_out_valid / i_out_ready o_speed_{front,back}_{right,left}, o_was_scaled
// cfg      in   i_cfg_we                  i_cfg_addr, i_cfg_wdata
//
// a result follows its input beat after p scaling passes (p = 0..29 with the default
// step) and four 16-step divisions, one per wheel; a command whose scale is exhausted
// while still over the limit returns all four speeds as zero
// one command is in flight at a time; the next is taken once the result sits in the
// output register, which holds it while o_out_valid waits on i_out_ready
// synchronous active-low reset restores the register defaults and empties the output
// Top level of the mecanum wheel speed limiter. Depends on mwsl_pkg, mwsl_regs,
// mwsl_ctrl and mwsl_dp.
module mecanum_wheel_speed_limiter #(
    parameter logic [mwsl_pkg::SCL_W-1:0] SCALE_STEP = mwsl_pkg::SCALE_STEP
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [mwsl_pkg::IN_W-1:0]     i_vel_forward,
    input  logic signed [mwsl_pkg::IN_W-1:0]     i_vel_lateral,
    input  logic signed [mwsl_pkg::IN_W-1:0]     i_yaw_rate,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [mwsl_pkg::SPD_W-1:0]    o_speed_front_right,
    output logic signed [mwsl_pkg::SPD_W-1:0]    o_speed_front_left,
    output logic signed [mwsl_pkg::SPD_W-1:0]    o_speed_back_left,
    output logic signed [mwsl_pkg::SPD_W-1:0]    o_speed_back_right,
    output logic                                 o_was_scaled,
    input  logic                                 i_cfg_we,
    input  logic [mwsl_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [mwsl_pkg::CFG_DATA_W-1:0]      i_cfg_wdata
);

    mwsl_pkg::t_cfg w_cfg;
    mwsl_pkg::t_cmd w_cmd;
    mwsl_pkg::t_sts w_sts;

    mwsl_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    mwsl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    mwsl_dp #(
        .SCALE_STEP (SCALE_STEP)
    ) u_dp (
        .i_clk               (i_clk),
        .i_cmd               (w_cmd),
        .o_sts               (w_sts),
        .i_cfg               (w_cfg),
        .i_vel_forward       (i_vel_forward),
        .i_vel_lateral       (i_vel_lateral),
        .i_yaw_rate          (i_yaw_rate),
        .o_speed_front_right (o_speed_front_right),
        .o_speed_front_left  (o_speed_front_left),
        .o_speed_back_left   (o_speed_back_left),
        .o_speed_back_right  (o_speed_back_right),
        .o_was_scaled        (o_was_scaled)
    );

endmodule

>>> sv/mwsl_chk.sv
// mwsl_chk: port-level checks for the wheel speed limiter, bound to the top level.
// Depends on mwsl_pkg and mecanum_wheel_speed_limiter.
module mwsl_chk (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_in_valid,
    input logic                                 o_in_ready,
    input logic                                 o_out_valid,
    input logic                                 i_out_ready,
    input logic signed [mwsl_pkg::SPD_W-1:0]    o_speed_front_right,
    input logic signed [mwsl_pkg::SPD_W-1:0]    o_speed_front_left,
    input logic signed [mwsl_pkg::SPD_W-1:0]    o_speed_back_left,
    input logic signed [mwsl_pkg::SPD_W-1:0]    o_speed_back_right,
    input logic                                 o_was_scaled
);

    // a stalled result beat holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid
            && $stable(o_speed_front_right) && $stable(o_speed_front_left)
            && $stable(o_speed_back_left) && $stable(o_speed_back_right)
            && $stable(o_was_scaled))
        else $error("result beat changed while stalled");

    a_rst_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("output valid after reset");

    // a command keeps the block busy after its input beat
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken again right after a beat");

    // a new result appears only as the sequencer returns to idle
    a_rise_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> o_in_ready)
        else $error("result appeared while still busy");

    a_no_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !$rose(o_out_valid) ##1 !$rose(o_out_valid))
        else $error("result too soon after input beat");

endmodule

bind mecanum_wheel_speed_limiter mwsl_chk u_chk (.*);
